### hdl/dmxtx_pkg.sv
// ============================================================================
// DMX512 transmit sequencer package
// Shared widths, reset values, register indexes and types.
// ============================================================================
`default_nettype none

package dmxtx_pkg;

    localparam int SLOT_W     = 10;
    localparam int BYTE_W     = 8;
    localparam int WAIT_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int MAX_SLOTS_DEF = 512;
    localparam int MIN_SLOTS_DEF = 24;

    localparam logic [WAIT_W-1:0] IDLE_WAIT_RST = 8'd25;
    localparam logic [WAIT_W-1:0] MAB_WAIT_RST  = 8'd70;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAB_WAIT   = 2'd2;

    localparam logic FUNC_FIFO_EMPTY = 1'b0;
    localparam logic FUNC_SLOT_WRITE = 1'b1;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_store_cmd;

endpackage

`default_nettype wire

### hdl/dmxtx_if.sv
// ============================================================================
// DMX512 transmit sequencer channels
// Valid/ready channels for the request words and the transmit words.
// ============================================================================
`default_nettype none

interface dmxtx_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [dmxtx_pkg::SLOT_W-1:0] slot_index;
    logic [dmxtx_pkg::BYTE_W-1:0] slot_value;

    modport source (output valid, output func, output slot_index, output slot_value,
                    input ready);
    modport sink   (input valid, input func, input slot_index, input slot_value,
                    output ready);
endinterface

interface dmxtx_out_if;
    logic                        valid;
    logic                        ready;
    logic [dmxtx_pkg::BYTE_W-1:0] tx_byte;
    logic                        break_format;
    logic [dmxtx_pkg::SLOT_W-1:0] frame_slot;

    modport source (output valid, output tx_byte, output break_format, output frame_slot,
                    input ready);
    modport sink   (input valid, input tx_byte, input break_format, input frame_slot,
                    output ready);
endinterface

`default_nettype wire

### hdl/dmxtx_slot_store.sv
// ============================================================================
// DMX512 slot store
// Start code and data slot memory with a registered read and a clearing
// pass that zeroes every entry after reset.
// ============================================================================
`default_nettype none

module dmxtx_slot_store #(
    parameter int MAX_SLOTS = dmxtx_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dmxtx_pkg::t_store_cmd        i_cmd,
    output logic [dmxtx_pkg::BYTE_W-1:0]      o_rd_data,
    output logic                              o_clearing
);
    import dmxtx_pkg::*;

    localparam int DEPTH  = MAX_SLOTS + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(MAX_SLOTS)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.we) begin
            r_mem[i_cmd.waddr[ADDR_W-1:0]] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rd_data <= r_mem[i_cmd.raddr[ADDR_W-1:0]];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

### hdl/dmx512_frame_transmit_sequencer.sv
// ============================================================================
// DMX512 frame transmit sequencer
// Turns transmit-FIFO-empty events into the byte sequence of DMX512 frames.
// ============================================================================
// The block takes one word per clock cycle unless held off by the clearing
// pass or a full output path: either a transmit-FIFO-empty event or a write
// into the slot store. A FIFO-empty event that sends a byte passes through the
// registered read of the slot store and then the output register; a stage
// between them lets the block keep taking words while one transmit word waits.
// After reset the slot store is zeroed one entry per cycle, and no word is
// accepted until that pass ends; configuration writes are taken at all times.
`default_nettype none

module dmx512_frame_transmit_sequencer #(
    parameter int MAX_SLOTS = dmxtx_pkg::MAX_SLOTS_DEF,
    parameter int MIN_SLOTS = dmxtx_pkg::MIN_SLOTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [dmxtx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dmxtx_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    dmxtx_in_if.sink                              i_in,
    dmxtx_out_if.source                           o_out
);
    import dmxtx_pkg::*;

    localparam logic [2:0] PH_BREAK      = 3'd0;
    localparam logic [2:0] PH_START      = 3'd1;
    localparam logic [2:0] PH_DATA       = 3'd2;
    localparam logic [2:0] PH_IDLE       = 3'd3;
    localparam logic [2:0] PH_BREAK_SENT = 3'd4;

    logic [SLOT_W-1:0] r_slot_count;
    logic [WAIT_W-1:0] r_idle_wait;
    logic [WAIT_W-1:0] r_mab_wait;

    logic [2:0]        r_phase, n_phase;
    logic [WAIT_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_next, n_next;

    logic              r_s1_valid;
    logic              r_s1_zero;
    logic              r_s1_fmt;
    logic [SLOT_W-1:0] r_s1_slot;

    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_fmt;
    logic [SLOT_W-1:0] r_o_slot;

    logic              clearing;
    logic [BYTE_W-1:0] rd_data;
    t_store_cmd        store_cmd;

    logic              s1_move;
    logic              in_ready;
    logic              acc;
    logic              emit;
    logic              emit_zero;
    logic              emit_fmt;
    logic [SLOT_W-1:0] emit_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic [WAIT_W:0]   cnt_inc;
    logic [WAIT_W:0]   wait_lim;
    logic [SLOT_W:0]   slot_inc;
    logic              in_range;
    logic [SLOT_W-1:0] cfg_slots;

    dmxtx_slot_store #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (store_cmd),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    assign s1_move  = r_s1_valid && (!r_o_valid || o_out.ready);
    assign in_ready = !clearing && (!r_s1_valid || s1_move);
    assign acc      = i_in.valid && in_ready;

    assign cnt_inc  = {1'b0, r_cnt} + 1'b1;
    assign wait_lim = (r_phase == PH_BREAK_SENT) ? {1'b0, r_mab_wait} : {1'b0, r_idle_wait};
    assign slot_inc = {1'b0, r_next} + 1'b1;
    assign in_range = r_next <= SLOT_W'(MAX_SLOTS);

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_next    = r_next;
        emit      = 1'b0;
        emit_zero = 1'b0;
        emit_fmt  = 1'b0;
        emit_slot = '0;
        rd_addr   = '0;
        case (r_phase)
            PH_BREAK: begin
                n_phase   = PH_BREAK_SENT;
                n_cnt     = '0;
                emit      = 1'b1;
                emit_zero = 1'b1;
                emit_fmt  = 1'b1;
            end
            PH_START: begin
                n_next  = SLOT_W'(1);
                n_phase = PH_DATA;
                emit    = 1'b1;
            end
            PH_DATA: begin
                emit      = 1'b1;
                emit_zero = !in_range;
                emit_slot = r_next;
                rd_addr   = in_range ? r_next : '0;
                n_next    = slot_inc[SLOT_W-1:0];
                if (slot_inc > {1'b0, r_slot_count}) begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            end
            PH_IDLE, PH_BREAK_SENT: begin
                n_cnt = cnt_inc[WAIT_W] ? '1 : cnt_inc[WAIT_W-1:0];
                if (cnt_inc > wait_lim) begin
                    n_phase = (r_phase == PH_IDLE) ? PH_BREAK : PH_START;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        store_cmd.we    = acc && (i_in.func == FUNC_SLOT_WRITE)
                          && (i_in.slot_index <= SLOT_W'(MAX_SLOTS));
        store_cmd.waddr = i_in.slot_index;
        store_cmd.wdata = i_in.slot_value;
        store_cmd.re    = acc && (i_in.func == FUNC_FIFO_EMPTY) && emit;
        store_cmd.raddr = rd_addr;
    end

    always_comb begin
        cfg_slots = i_cfg_wdata[SLOT_W-1:0];
        if (cfg_slots < SLOT_W'(MIN_SLOTS)) begin
            cfg_slots = SLOT_W'(MIN_SLOTS);
        end
        if (cfg_slots > SLOT_W'(MAX_SLOTS)) begin
            cfg_slots = SLOT_W'(MAX_SLOTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_W'(MAX_SLOTS);
            r_idle_wait  <= IDLE_WAIT_RST;
            r_mab_wait   <= MAB_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLOT_COUNT: r_slot_count <= cfg_slots;
                CFG_IDLE_WAIT:  r_idle_wait  <= i_cfg_wdata[WAIT_W-1:0];
                CFG_MAB_WAIT:   r_mab_wait   <= i_cfg_wdata[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cnt      <= '0;
            r_next     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (acc && (i_in.func == FUNC_FIFO_EMPTY)) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_next  <= n_next;
            end
            if (acc) begin
                r_s1_valid <= (i_in.func == FUNC_FIFO_EMPTY) && emit;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_cmd.re) begin
            r_s1_zero <= emit_zero;
            r_s1_fmt  <= emit_fmt;
            r_s1_slot <= emit_slot;
        end
        if (s1_move) begin
            r_o_byte <= r_s1_zero ? '0 : rd_data;
            r_o_fmt  <= r_s1_fmt;
            r_o_slot <= r_s1_slot;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_o_valid;
    assign o_out.tx_byte       = r_o_byte;
    assign o_out.break_format  = r_o_fmt;
    assign o_out.frame_slot    = r_o_slot;

endmodule

`default_nettype wire

### hdl/dmxtx_checker.sv
// ============================================================================
// DMX512 transmit sequencer checker
// Port-level properties of the sequencer, attached to the top level by bind.
// ============================================================================
`default_nettype none

module dmxtx_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [dmxtx_pkg::BYTE_W-1:0] i_tx_byte,
    input wire logic                         i_break_format,
    input wire logic [dmxtx_pkg::SLOT_W-1:0] i_frame_slot
);
    import dmxtx_pkg::*;

    // A break word is always a zero byte tagged as slot zero.
    a_break_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_break_format) |-> (i_tx_byte == '0 && i_frame_slot == '0))
        else $error("break word with nonzero byte or slot");

    // The slot store clearing pass holds off every word right after reset.
    a_clear_holds_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("word accepted during slot store clearing");

    // No transmit word appears in the cycle after reset.
    a_no_word_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("transmit word right after reset");

    // A stalled transmit word stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_tx_byte) && $stable(i_break_format)
             && $stable(i_frame_slot)))
        else $error("stalled transmit word changed");

endmodule

bind dmx512_frame_transmit_sequencer dmxtx_checker u_dmxtx_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_tx_byte      (o_out.tx_byte),
    .i_break_format (o_out.break_format),
    .i_frame_slot   (o_out.frame_slot)
);

`default_nettype wire
